// File: design/nps_pkg.sv
// nearest point search: shared constants and codes
// used by the channel interfaces and by every design module
`timescale 1ns / 1ps

package nps_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int INDEX_BITS     = 16;
  localparam int LIMIT_BITS     = 34;

  // best distance starts here for each search and only shrinks within it
  localparam int START_DISTANCE = 10000;
  localparam int BEST_BITS      = 14;

  // an offset of REACH on one axis alone already reaches START_DISTANCE
  localparam int REACH          = 100;
  localparam int REACH_BITS     = 7;
  localparam int SQ_BITS        = 2 * REACH_BITS;
  localparam int DIST_BITS      = SQ_BITS + 1;

  typedef enum logic {
    ACT_BEGIN = 1'b0,
    ACT_POINT = 1'b1
  } action_t;

endpackage

// File: design/nps_if.sv
// valid/ready channel interfaces for query/point items and search results
// depends on nps_pkg for default widths
`timescale 1ns / 1ps

interface nps_item_if #(
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [COORD_BITS-1:0]      coord_x;
  logic signed [COORD_BITS-1:0]      coord_y;
  logic [nps_pkg::INDEX_BITS-1:0]    element_id;
  logic [nps_pkg::INDEX_BITS-1:0]    point_id;
  logic                              last;

  modport source (output valid, action, coord_x, coord_y, element_id, point_id, last,
                  input ready);
  modport sink   (input valid, action, coord_x, coord_y, element_id, point_id, last,
                  output ready);
endinterface

interface nps_result_if #(
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic signed [COORD_BITS-1:0]      near_x;
  logic signed [COORD_BITS-1:0]      near_y;
  logic [nps_pkg::INDEX_BITS-1:0]    near_element;
  logic [nps_pkg::INDEX_BITS-1:0]    near_point;

  modport source (output valid, found, near_x, near_y, near_element, near_point,
                  input ready);
  modport sink   (input valid, found, near_x, near_y, near_element, near_point,
                  output ready);
endinterface

// File: design/nearest_point_search.sv
// nearest point search top level: input register, distance test, search state, result register
// the result is registered as the last item of a search leaves the input register
// throughput: one item per cycle unless stalled; combinational distance test, registered best
// input stalls only while a finished result is held and the next last item waits behind it
// reset (rst, synchronous): query (0,0), best cleared, gravity_limit 10000, no result pending
// depends on nps_pkg, nps_if, nps_dist and nps_track
`timescale 1ns / 1ps

module nearest_point_search #(
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [nps_pkg::LIMIT_BITS-1:0]  cfg_wr_data,
  nps_item_if.sink                        item_in,
  nps_result_if.source                    result_out
);

  logic [nps_pkg::LIMIT_BITS-1:0]  gravity_limit;

  // input register
  logic                            stage_valid;
  logic                            stage_action;
  logic                            stage_last;
  logic signed [COORD_BITS-1:0]    stage_x;
  logic signed [COORD_BITS-1:0]    stage_y;
  logic [nps_pkg::INDEX_BITS-1:0]  stage_element;
  logic [nps_pkg::INDEX_BITS-1:0]  stage_point;

  // result register
  logic                            out_valid;
  logic                            out_found;
  logic signed [COORD_BITS-1:0]    out_x;
  logic signed [COORD_BITS-1:0]    out_y;
  logic [nps_pkg::INDEX_BITS-1:0]  out_element;
  logic [nps_pkg::INDEX_BITS-1:0]  out_point;

  logic                            slot_free;
  logic                            stall;
  logic                            advance;
  logic                            capture;
  logic [nps_pkg::DIST_BITS-1:0]   point_dist;

  logic signed [COORD_BITS-1:0]    query_x;
  logic signed [COORD_BITS-1:0]    query_y;
  logic [nps_pkg::BEST_BITS-1:0]   best_dist;
  logic                            res_found;
  logic signed [COORD_BITS-1:0]    res_x;
  logic signed [COORD_BITS-1:0]    res_y;
  logic [nps_pkg::INDEX_BITS-1:0]  res_element;
  logic [nps_pkg::INDEX_BITS-1:0]  res_point;

  assign slot_free = !out_valid || result_out.ready;
  assign stall     = stage_valid && stage_last && !slot_free;
  assign advance   = stage_valid && !stall;

  assign item_in.ready = !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_limit <= nps_pkg::LIMIT_BITS'(nps_pkg::START_DISTANCE);
    end else if (cfg_wr_en) begin
      gravity_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      stage_action  <= item_in.action;
      stage_last    <= item_in.last;
      stage_x       <= item_in.coord_x;
      stage_y       <= item_in.coord_y;
      stage_element <= item_in.element_id;
      stage_point   <= item_in.point_id;
    end
  end

  nps_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .coord_x       (stage_x),
    .coord_y       (stage_y),
    .query_x       (query_x),
    .query_y       (query_y),
    .best_dist     (best_dist),
    .gravity_limit (gravity_limit),
    .sq_sum        (point_dist),
    .capture       (capture)
  );

  nps_track #(.COORD_BITS(COORD_BITS)) u_track (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .action      (stage_action),
    .last        (stage_last),
    .coord_x     (stage_x),
    .coord_y     (stage_y),
    .element_id  (stage_element),
    .point_id    (stage_point),
    .capture     (capture),
    .point_dist  (point_dist),
    .query_x     (query_x),
    .query_y     (query_y),
    .best_dist   (best_dist),
    .res_found   (res_found),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_element (res_element),
    .res_point   (res_point)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_last) begin
      out_found   <= res_found;
      out_x       <= res_x;
      out_y       <= res_y;
      out_element <= res_element;
      out_point   <= res_point;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.found        = out_found;
  assign result_out.near_x       = out_x;
  assign result_out.near_y       = out_y;
  assign result_out.near_element = out_element;
  assign result_out.near_point   = out_point;

`ifndef SYNTH
  // a result appears only after a last item left the input register
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid && stage_last))
    else $error("result without a last item");

  // a miss reports zero indices
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_element == '0 && out_point == '0))
    else $error("miss with nonzero indices");

  // best distance never grows past its start value
  assert property (@(posedge clk) disable iff (rst)
    best_dist <= nps_pkg::BEST_BITS'(nps_pkg::START_DISTANCE))
    else $error("best distance above start value");
`endif

endmodule

// File: design/nps_dist.sv
// squared distance test of one stored point against the query
// depends on nps_pkg for distance widths and constants
`timescale 1ns / 1ps

module nps_dist #(
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]      coord_x,
  input  logic signed [COORD_BITS-1:0]      coord_y,
  input  logic signed [COORD_BITS-1:0]      query_x,
  input  logic signed [COORD_BITS-1:0]      query_y,
  input  logic [nps_pkg::BEST_BITS-1:0]     best_dist,
  input  logic [nps_pkg::LIMIT_BITS-1:0]    gravity_limit,
  output logic [nps_pkg::DIST_BITS-1:0]     sq_sum,
  output logic                              capture
);

  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0]              dx;
  logic signed [DW-1:0]              dy;
  logic [DW-1:0]                     ax;
  logic [DW-1:0]                     ay;
  logic                              near_x;
  logic                              near_y;
  logic [nps_pkg::SQ_BITS-1:0]       sx;
  logic [nps_pkg::SQ_BITS-1:0]       sy;

  assign dx = {coord_x[COORD_BITS-1], coord_x} - {query_x[COORD_BITS-1], query_x};
  assign dy = {coord_y[COORD_BITS-1], coord_y} - {query_y[COORD_BITS-1], query_y};
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  // beyond reach on either axis the distance cannot beat the best, which never
  // exceeds the start distance, so only the short offsets need squaring
  assign near_x = ax < DW'(nps_pkg::REACH);
  assign near_y = ay < DW'(nps_pkg::REACH);

  assign sx     = ax[nps_pkg::REACH_BITS-1:0] * ax[nps_pkg::REACH_BITS-1:0];
  assign sy     = ay[nps_pkg::REACH_BITS-1:0] * ay[nps_pkg::REACH_BITS-1:0];
  assign sq_sum = nps_pkg::DIST_BITS'(sx) + nps_pkg::DIST_BITS'(sy);

  assign capture = near_x && near_y
                && (sq_sum < nps_pkg::DIST_BITS'(best_dist))
                && (nps_pkg::LIMIT_BITS'(sq_sum) < gravity_limit);

endmodule

// File: design/nps_track.sv
// search state: query point, best point so far, and result forming
// depends on nps_pkg for codes and widths
`timescale 1ns / 1ps

module nps_track #(
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              action,
  input  logic                              last,
  input  logic signed [COORD_BITS-1:0]      coord_x,
  input  logic signed [COORD_BITS-1:0]      coord_y,
  input  logic [nps_pkg::INDEX_BITS-1:0]    element_id,
  input  logic [nps_pkg::INDEX_BITS-1:0]    point_id,
  input  logic                              capture,
  input  logic [nps_pkg::DIST_BITS-1:0]     point_dist,
  output logic signed [COORD_BITS-1:0]      query_x,
  output logic signed [COORD_BITS-1:0]      query_y,
  output logic [nps_pkg::BEST_BITS-1:0]     best_dist,
  output logic                              res_found,
  output logic signed [COORD_BITS-1:0]      res_x,
  output logic signed [COORD_BITS-1:0]      res_y,
  output logic [nps_pkg::INDEX_BITS-1:0]    res_element,
  output logic [nps_pkg::INDEX_BITS-1:0]    res_point
);

  logic signed [COORD_BITS-1:0]    best_x;
  logic signed [COORD_BITS-1:0]    best_y;
  logic [nps_pkg::INDEX_BITS-1:0]  best_element;
  logic [nps_pkg::INDEX_BITS-1:0]  best_point;
  logic                            have_best;

  // state after this item, before the end-of-search clear
  logic signed [COORD_BITS-1:0]    query_x_upd;
  logic signed [COORD_BITS-1:0]    query_y_upd;
  logic [nps_pkg::BEST_BITS-1:0]   best_dist_upd;
  logic signed [COORD_BITS-1:0]    best_x_upd;
  logic signed [COORD_BITS-1:0]    best_y_upd;
  logic [nps_pkg::INDEX_BITS-1:0]  best_element_upd;
  logic [nps_pkg::INDEX_BITS-1:0]  best_point_upd;
  logic                            have_best_upd;

  logic [nps_pkg::BEST_BITS-1:0]   best_dist_next;
  logic signed [COORD_BITS-1:0]    best_x_next;
  logic signed [COORD_BITS-1:0]    best_y_next;
  logic [nps_pkg::INDEX_BITS-1:0]  best_element_next;
  logic [nps_pkg::INDEX_BITS-1:0]  best_point_next;
  logic                            have_best_next;

  logic                            clear_search;

  always_comb begin
    query_x_upd      = query_x;
    query_y_upd      = query_y;
    best_dist_upd    = best_dist;
    best_x_upd       = best_x;
    best_y_upd       = best_y;
    best_element_upd = best_element;
    best_point_upd   = best_point;
    have_best_upd    = have_best;
    clear_search     = 1'b0;

    if (step && action == nps_pkg::ACT_BEGIN) begin
      // a begin starts from an empty search, also for its own result
      query_x_upd      = coord_x;
      query_y_upd      = coord_y;
      best_dist_upd    = nps_pkg::BEST_BITS'(nps_pkg::START_DISTANCE);
      best_x_upd       = '0;
      best_y_upd       = '0;
      best_element_upd = '0;
      best_point_upd   = '0;
      have_best_upd    = 1'b0;
      clear_search     = 1'b1;
    end else if (step && capture) begin
      // a captured distance is below the start distance, so it fits
      best_dist_upd    = point_dist[nps_pkg::BEST_BITS-1:0];
      best_x_upd       = coord_x;
      best_y_upd       = coord_y;
      best_element_upd = element_id;
      best_point_upd   = point_id;
      have_best_upd    = 1'b1;
    end

    if (step && last) begin
      clear_search = 1'b1;
    end

    if (clear_search) begin
      best_dist_next    = nps_pkg::BEST_BITS'(nps_pkg::START_DISTANCE);
      best_x_next       = '0;
      best_y_next       = '0;
      best_element_next = '0;
      best_point_next   = '0;
      have_best_next    = 1'b0;
    end else begin
      best_dist_next    = best_dist_upd;
      best_x_next       = best_x_upd;
      best_y_next       = best_y_upd;
      best_element_next = best_element_upd;
      best_point_next   = best_point_upd;
      have_best_next    = have_best_upd;
    end

    res_found   = have_best_upd;
    res_x       = have_best_upd ? best_x_upd : query_x_upd;
    res_y       = have_best_upd ? best_y_upd : query_y_upd;
    res_element = have_best_upd ? best_element_upd : '0;
    res_point   = have_best_upd ? best_point_upd : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x      <= '0;
      query_y      <= '0;
      best_dist    <= nps_pkg::BEST_BITS'(nps_pkg::START_DISTANCE);
      best_x       <= '0;
      best_y       <= '0;
      best_element <= '0;
      best_point   <= '0;
      have_best    <= 1'b0;
    end else begin
      query_x      <= query_x_upd;
      query_y      <= query_y_upd;
      best_dist    <= best_dist_next;
      best_x       <= best_x_next;
      best_y       <= best_y_next;
      best_element <= best_element_next;
      best_point   <= best_point_next;
      have_best    <= have_best_next;
    end
  end

endmodule

// File: sim/tb.sv
// testbench for nearest_point_search: directed and random search sequences
// with an in-bench tracker of the nearest point; depends on nps_pkg, nps_if and nearest_point_search
`timescale 1ns / 1ps

module tb;

  localparam int CB = nps_pkg::COORD_BITS_DEF;
  localparam int IB = nps_pkg::INDEX_BITS;
  localparam int LB = nps_pkg::LIMIT_BITS;
  localparam int STALL_LIMIT = 5000;
  localparam logic [LB-1:0] LIMIT_MAX = '1;
  localparam int RANDOM_ITEMS = 400;

  typedef struct {
    nps_pkg::action_t        act;
    logic signed [CB-1:0]    x;
    logic signed [CB-1:0]    y;
    logic [IB-1:0]           elem;
    logic [IB-1:0]           pt;
    logic                    last;
  } search_item_t;

  typedef struct {
    logic                    found;
    logic signed [CB-1:0]    x;
    logic signed [CB-1:0]    y;
    logic [IB-1:0]           elem;
    logic [IB-1:0]           pt;
  } match_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [LB-1:0] cfg_wr_data;

  nps_item_if #(.COORD_BITS(CB)) item_ch ();
  nps_result_if #(.COORD_BITS(CB)) res_ch ();

  nearest_point_search #(.COORD_BITS(CB)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_in     (item_ch),
    .result_out  (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker state: mirrors the search registers of the block
  logic [LB-1:0]         model_limit;
  logic signed [CB-1:0]  q_x, q_y;
  logic [63:0]           best_dist;
  match_t                best;
  match_t                expected_matches[$];

  bit idle_on;
  int errors, n_items, n_results, n_found, n_limit_writes, stall_cycles;

  function automatic logic [63:0] sq_dist(input logic signed [CB-1:0] ax, ay, bx, by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return 64'(dx * dx) + 64'(dy * dy);
  endfunction

  function automatic void clear_best();
    best_dist = 64'(nps_pkg::START_DISTANCE);
    best = '{default: '0};
  endfunction

  function automatic void track_nearest(input search_item_t it);
    logic [63:0] d;
    if (it.act == nps_pkg::ACT_BEGIN) begin
      q_x = it.x;
      q_y = it.y;
      clear_best();
    end else begin
      d = sq_dist(it.x, it.y, q_x, q_y);
      // strictly below both, so the earlier point keeps a tie
      if (d < best_dist && d < model_limit) begin
        best_dist = d;
        best = '{1'b1, it.x, it.y, it.elem, it.pt};
      end
    end
    if (it.last) begin
      if (best.found) expected_matches.push_back(best);
      else expected_matches.push_back('{1'b0, q_x, q_y, '0, '0});
      clear_best();
    end
  endfunction

  function automatic search_item_t mk(nps_pkg::action_t a, int x, int y, int e, int p, bit l);
    search_item_t it;
    it.act = a;
    it.x = CB'(x);
    it.y = CB'(y);
    it.elem = IB'(e);
    it.pt = IB'(p);
    it.last = l;
    return it;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_idx();
    return int'($urandom_range(0, 65535));
  endfunction

  // random point around a center, clamped to the coordinate range
  function automatic int near(int center, int span);
    int v;
    v = center + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic send_item(input search_item_t it);
    while (idle_on && $urandom_range(0, 99) < 14) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.action     <= it.act;
    item_ch.coord_x    <= it.x;
    item_ch.coord_y    <= it.y;
    item_ch.element_id <= it.elem;
    item_ch.point_id   <= it.pt;
    item_ch.last       <= it.last;
    do @(posedge clk); while (!item_ch.ready);
    track_nearest(it);
    n_items++;
  endtask

  // stop sending, wait for all results, then let the pipeline empty
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LB-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    model_limit = v;
    n_limit_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void check_field(string name, logic signed [31:0] e,
                                      logic signed [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    match_t exp_m;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_results++;
      if (expected_matches.size() == 0) begin
        $display("%0t: unexpected result, expected none actual found=%0d x=%0d y=%0d",
                 $time, res_ch.found, res_ch.near_x, res_ch.near_y);
        errors++;
      end else begin
        exp_m = expected_matches.pop_front();
        if (res_ch.found) n_found++;
        check_field("found", exp_m.found, res_ch.found);
        check_field("near_x", exp_m.x, res_ch.near_x);
        check_field("near_y", exp_m.y, res_ch.near_y);
        check_field("near_element", exp_m.elem, res_ch.near_element);
        check_field("near_point", exp_m.pt, res_ch.near_point);
      end
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= !rst && !(idle_on && $urandom_range(0, 99) < 14);
  end

  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("tb NOT OK");
      $finish;
    end
  end

  // points before any begin are measured from the reset query (0,0)
  task automatic test_points_before_begin();
    send_item(mk(nps_pkg::ACT_POINT, 3, 4, 1, 2, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 99, 0, 3, 4, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 0, 100, 5, 6, 1'b1));
    send_item(mk(nps_pkg::ACT_POINT, 0, -99, 7, 8, 1'b1));
  endtask

  task automatic test_begin_with_last();
    send_item(mk(nps_pkg::ACT_BEGIN, 32767, -32768, 0, 0, 1'b1));
    send_item(mk(nps_pkg::ACT_BEGIN, -1, 0, 65535, 65535, 1'b1));
  endtask

  task automatic test_coord_extremes();
    send_item(mk(nps_pkg::ACT_BEGIN, -32768, -32768, 0, 0, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 32767, 32767, 65535, 65535, 1'b0));
    // exactly 10000 away: not strictly below the start distance
    send_item(mk(nps_pkg::ACT_POINT, -32768 + 60, -32768 + 80, 65535, 65535, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, -32768 + 59, -32768 + 80, 16'haaaa, 16'h5555, 1'b1));
  endtask

  task automatic test_tie_keeps_first();
    send_item(mk(nps_pkg::ACT_BEGIN, 100, -200, 0, 0, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 103, -196, 10, 1, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 97, -204, 11, 2, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 96, -197, 12, 3, 1'b1));
  endtask

  // a begin after a captured point must report its own empty search
  task automatic test_begin_after_capture();
    send_item(mk(nps_pkg::ACT_BEGIN, 0, 0, 0, 0, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 2, 2, 40, 41, 1'b0));
    send_item(mk(nps_pkg::ACT_BEGIN, 500, -500, 0, 0, 1'b1));
  endtask

  task automatic test_limit_settings();
    write_limit('0);
    send_item(mk(nps_pkg::ACT_BEGIN, 0, 0, 0, 0, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 0, 0, 1, 1, 1'b1));
    write_limit(LB'(1));
    send_item(mk(nps_pkg::ACT_POINT, 0, 0, 5, 6, 1'b1));
    write_limit(LIMIT_MAX);
    send_item(mk(nps_pkg::ACT_POINT, 1, 1, 7, 9, 1'b1));
    write_limit(LB'(50));
    send_item(mk(nps_pkg::ACT_POINT, 5, 5, 20, 21, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, -7, 1, 22, 23, 1'b0));
    send_item(mk(nps_pkg::ACT_POINT, 7, 0, 24, 25, 1'b1));
    write_limit(LB'(nps_pkg::START_DISTANCE));
  endtask

  // the query survives a result, so bare points start a new search
  task automatic test_query_reuse();
    send_item(mk(nps_pkg::ACT_BEGIN, 1000, 1000, 0, 0, 1'b1));
    send_item(mk(nps_pkg::ACT_POINT, 1010, 990, 33, 44, 1'b1));
  endtask

  task automatic test_random_searches();
    int sent, phase_mark, k, r, qx, qy;
    logic [63:0] wide;
    search_item_t it, first_pt;
    sent = 0;
    phase_mark = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = !(sent >= 150 && sent < 260);
      if (sent - phase_mark >= 80) begin
        phase_mark = sent;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0: write_limit('0);
          1: write_limit(LB'(1));
          2: write_limit(LIMIT_MAX);
          3: write_limit(wide[LB-1:0]);
          4: write_limit(LB'($urandom_range(1, 20000)));
          default: write_limit(LB'(nps_pkg::START_DISTANCE));
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 78) begin
        qx = rand_coord();
        qy = rand_coord();
        if ($urandom_range(0, 4) == 0) begin
          qx = $urandom_range(0, 1) ? 32767 : -32768;
          qy = $urandom_range(0, 1) ? 32767 : -32768;
        end
        send_item(mk(nps_pkg::ACT_BEGIN, qx, qy, rand_idx(), rand_idx(), 1'b0));
        sent++;
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
          if (i > 0 && $urandom_range(0, 9) == 0) begin
            it = first_pt;
            it.elem = IB'(rand_idx());
            it.pt = IB'(rand_idx());
          end else if ($urandom_range(0, 6) == 0) begin
            it = mk(nps_pkg::ACT_POINT, rand_coord(), rand_coord(), rand_idx(), rand_idx(),
                    1'b0);
          end else begin
            it = mk(nps_pkg::ACT_POINT, near(qx, 110), near(qy, 110), rand_idx(), rand_idx(),
                    1'b0);
          end
          it.last = (i == k - 1);
          if (i == 0) first_pt = it;
          send_item(it);
          sent++;
        end
      end else if (r < 86) begin
        send_item(mk(nps_pkg::ACT_BEGIN, rand_coord(), rand_coord(), rand_idx(), rand_idx(),
                     1'b1));
        sent++;
      end else if (r < 94) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          send_item(mk(nps_pkg::ACT_POINT, near(q_x, 110), near(q_y, 110), rand_idx(),
                       rand_idx(), i == k - 1));
          sent++;
        end
      end else begin
        // stray transaction that leaves a search open
        send_item(mk($urandom_range(0, 1) ? nps_pkg::ACT_POINT : nps_pkg::ACT_BEGIN,
                     rand_coord(), rand_coord(), rand_idx(), rand_idx(), 1'b0));
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.action     <= nps_pkg::ACT_BEGIN;
    item_ch.coord_x    <= '0;
    item_ch.coord_y    <= '0;
    item_ch.element_id <= '0;
    item_ch.point_id   <= '0;
    item_ch.last       <= 1'b0;
    idle_on = 1'b1;
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_found = 0;
    n_limit_writes = 0;
    model_limit = LB'(nps_pkg::START_DISTANCE);
    q_x = '0;
    q_y = '0;
    clear_best();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_points_before_begin();
    test_begin_with_last();
    test_coord_extremes();
    test_tie_keeps_first();
    test_begin_after_capture();
    test_limit_settings();
    test_query_reuse();
    test_random_searches();

    item_ch.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("searched %0d transactions, %0d results checked (%0d with a capture)",
             n_items, n_results, n_found);
    $display("gravity limit rewritten %0d times, %0d mismatches", n_limit_writes, errors);
    if (errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
